FILE: design/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set core.
// ----------------------------------------------------------------------------
package sus_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_ABSENT    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_LISTED    = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } t_cmd_beat;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [VALUE_W-1:0] element;
        logic [5:0]                count;
        logic                      last;
    } t_result_beat;

endpackage

FILE: design/sus_ram.sv
// ----------------------------------------------------------------------------
// sus_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sorted_unique_set_core.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_core
// Ascending set of signed 32-bit values with no repeats, held in a RAM.
// ----------------------------------------------------------------------------
// Usage: drive i_cmd and pulse i_start while o_busy is low; the beat is
// taken on that edge. Insert and remove walk the table once from the
// bottom, one RAM entry per cycle, shifting entries through the single
// read/write pass (insert carries each displaced entry one slot up,
// remove writes each later entry one slot down). A duplicate, full or
// not-present outcome ends an operation as soon as the search reaches
// the value. A dump emits one listed entry per cycle, starting once the
// first entry has been read from the RAM, the final one flagged by last;
// an empty set gives a single empty result in the cycle after the beat.
// Each result shows on o_result for one cycle with o_strobe high; the
// receiver cannot stall. A new command is taken in the cycle after the
// last result of the previous one is registered. Synchronous reset
// empties the set; RAM contents are not cleared, only the occupancy.
// ----------------------------------------------------------------------------
module sorted_unique_set_core
    import sus_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_cmd_beat    i_cmd,
    output logic         o_busy,
    output logic         o_strobe,
    output t_result_beat o_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                    r_state, n_state;
    logic [1:0]                r_cmd, n_cmd;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]             r_occ, n_occ;
    logic [CW-1:0]             r_ra, n_ra;
    logic                      r_rv, n_rv;
    logic [AW-1:0]             r_pa, n_pa;
    logic                      r_found, n_found;
    logic signed [VALUE_W-1:0] r_carry, n_carry;
    logic                      r_strobe, n_strobe;
    t_result_beat              r_res, n_res;
    t_result_beat              res_d;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic                      ram_re;
    logic [VALUE_W-1:0]        ram_rdata;
    logic signed [VALUE_W-1:0] rd;
    logic                      rd_lt, rd_eq, full;
    logic [CW+5:0]             cnt_ext;

    sus_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ra[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd      = $signed(ram_rdata);
    assign rd_lt   = rd < r_val;
    assign rd_eq   = rd == r_val;
    assign full    = r_occ == CW'(CAPACITY);
    assign cnt_ext = {6'd0, n_occ};

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_occ     = r_occ;
        n_ra      = r_ra;
        n_rv      = r_rv;
        n_pa      = r_pa;
        n_found   = r_found;
        n_carry   = r_carry;
        n_strobe  = 1'b0;
        n_res     = r_res;
        n_res.count = '0;
        ram_we    = 1'b0;
        ram_waddr = r_pa;
        ram_wdata = r_val;
        ram_re    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd.command;
                    n_val   = i_cmd.value;
                    n_ra    = '0;
                    n_rv    = 1'b0;
                    n_found = 1'b0;
                    case (i_cmd.command)
                        CMD_INSERT, CMD_REMOVE: begin
                            n_state = S_WALK;
                        end
                        CMD_DUMP: begin
                            if (r_occ == '0) begin
                                n_strobe      = 1'b1;
                                n_res.status  = ST_EMPTY;
                                n_res.element = i_cmd.value;
                                n_res.last    = 1'b1;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_ra < r_occ) begin
                    ram_re = 1'b1;
                    n_ra   = r_ra + 1'b1;
                    n_rv   = 1'b1;
                    n_pa   = r_ra[AW-1:0];
                end else begin
                    n_rv = 1'b0;
                end

                n_res.element = r_val;
                n_res.last    = 1'b1;

                if (r_rv) begin
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (r_found) begin
                                ram_we    = 1'b1;
                                ram_wdata = r_carry;
                                n_carry   = rd;
                            end else if (rd_eq) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_DUPLICATE;
                                n_state      = S_IDLE;
                            end else if (!rd_lt) begin
                                if (full) begin
                                    n_strobe     = 1'b1;
                                    n_res.status = ST_FULL;
                                    n_state      = S_IDLE;
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_wdata = r_val;
                                    n_carry   = rd;
                                    n_found   = 1'b1;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_found) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_pa - 1'b1;
                                ram_wdata = rd;
                            end else if (rd_eq) begin
                                n_found = 1'b1;
                            end else if (!rd_lt) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_ABSENT;
                                n_state      = S_IDLE;
                            end
                        end
                        default: begin
                            n_strobe      = 1'b1;
                            n_res.status  = ST_LISTED;
                            n_res.element = rd;
                            n_res.last    = r_ra == r_occ;
                            if (r_ra == r_occ) begin
                                n_state = S_IDLE;
                            end
                        end
                    endcase
                end else if (r_ra == r_occ) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (full && !r_found) begin
                                n_res.status = ST_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                ram_waddr    = r_occ[AW-1:0];
                                ram_wdata    = r_found ? r_carry : r_val;
                                n_occ        = r_occ + 1'b1;
                                n_res.status = ST_INSERTED;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_found) begin
                                n_occ        = r_occ - 1'b1;
                                n_res.status = ST_REMOVED;
                            end else begin
                                n_res.status = ST_ABSENT;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res_d       = n_res;
        res_d.count = cnt_ext[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_ra     <= '0;
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_ra     <= n_ra;
            r_rv     <= n_rv;
            r_found  <= n_found;
            r_strobe <= n_strobe;
        end
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_pa    <= n_pa;
        r_carry <= n_carry;
        if (n_strobe) begin
            r_res <= res_d;
        end
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_ra <= r_occ)
        else $error("read pointer past occupancy");

    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_WALK)
        else $error("RAM write outside walk");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_res.status == ST_INSERTED |-> r_occ == $past(r_occ) + 1'b1)
        else $error("insert did not grow the set");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_res.status == ST_REMOVED |-> r_occ == $past(r_occ) - 1'b1)
        else $error("remove did not shrink the set");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_unique_set_core: a directed table of
// insert/remove/dump beats, then random traffic in three sender-idle settings,
// each result beat checked against a typed row or a shadow copy of the set.
// ----------------------------------------------------------------------------
module tb_top;
    import sus_pkg::*;

    localparam int         CAPACITY   = CAPACITY_DEF;
    localparam int         PHASE_CMDS = 82;
    localparam int         STALL_MAX  = 2000;
    localparam int         SETTLE     = CAPACITY + 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_cmd_beat    beat;
        logic         typed;
        t_result_beat want;
    } t_row;

    localparam int NROWS = 21;
    localparam t_row ROWS [0:NROWS-1] = '{
        '{'{CMD_DUMP,   32'h0000_0000}, 1'b1, '{ST_EMPTY,     32'h0000_0000, 6'd0, 1'b1}},
        '{'{CMD_REMOVE, 32'h0000_0005}, 1'b1, '{ST_ABSENT,    32'h0000_0005, 6'd0, 1'b1}},
        '{'{CMD_UNUSED, 32'h0000_1234}, 1'b0, '0},
        '{'{CMD_INSERT, 32'h7FFF_FFFF}, 1'b1, '{ST_INSERTED,  32'h7FFF_FFFF, 6'd1, 1'b1}},
        '{'{CMD_INSERT, 32'h8000_0000}, 1'b1, '{ST_INSERTED,  32'h8000_0000, 6'd2, 1'b1}},
        '{'{CMD_INSERT, 32'h0000_0000}, 1'b1, '{ST_INSERTED,  32'h0000_0000, 6'd3, 1'b1}},
        '{'{CMD_INSERT, 32'hFFFF_FFFF}, 1'b1, '{ST_INSERTED,  32'hFFFF_FFFF, 6'd4, 1'b1}},
        '{'{CMD_INSERT, 32'h0000_0001}, 1'b1, '{ST_INSERTED,  32'h0000_0001, 6'd5, 1'b1}},
        '{'{CMD_INSERT, 32'h8000_0000}, 1'b1, '{ST_DUPLICATE, 32'h8000_0000, 6'd5, 1'b1}},
        '{'{CMD_INSERT, 32'h7FFF_FFFF}, 1'b1, '{ST_DUPLICATE, 32'h7FFF_FFFF, 6'd5, 1'b1}},
        '{'{CMD_DUMP,   32'h0000_0000}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF}, 1'b1, '{ST_REMOVED,   32'hFFFF_FFFF, 6'd4, 1'b1}},
        '{'{CMD_REMOVE, 32'hFFFF_FFFF}, 1'b1, '{ST_ABSENT,    32'hFFFF_FFFF, 6'd4, 1'b1}},
        '{'{CMD_REMOVE, 32'h8000_0000}, 1'b1, '{ST_REMOVED,   32'h8000_0000, 6'd3, 1'b1}},
        '{'{CMD_REMOVE, 32'h7FFF_FFFF}, 1'b1, '{ST_REMOVED,   32'h7FFF_FFFF, 6'd2, 1'b1}},
        '{'{CMD_DUMP,   32'hFFFF_FFFF}, 1'b0, '0},
        '{'{CMD_UNUSED, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{CMD_REMOVE, 32'h0000_0000}, 1'b1, '{ST_REMOVED,   32'h0000_0000, 6'd1, 1'b1}},
        '{'{CMD_REMOVE, 32'h0000_0001}, 1'b1, '{ST_REMOVED,   32'h0000_0001, 6'd0, 1'b1}},
        '{'{CMD_DUMP,   32'h55AA_55AA}, 1'b1, '{ST_EMPTY,     32'h55AA_55AA, 6'd0, 1'b1}},
        '{'{CMD_INSERT, 32'hAAAA_AAAA}, 1'b0, '0}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         i_start;
    t_cmd_beat    i_cmd;
    logic         o_busy;
    logic         o_strobe;
    t_result_beat o_result;

    sorted_unique_set_core #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    logic signed [VALUE_W-1:0] shadow [CAPACITY];
    int                        held;
    t_result_beat              results_due [$];
    t_result_beat              fresh [$];
    t_result_beat              want;
    logic                      row_typed;
    t_result_beat              row_want;
    logic                      beat_taken;
    int                        idle_pct;
    int                        failures;
    int                        n_beats;
    int                        n_results;
    int                        peak_held;
    int                        full_rejects;
    int                        dup_hits;
    int                        stall_run;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // shadow set update; returns the result beats one command produces
    function automatic void set_step(input t_cmd_beat b, ref t_result_beat outq [$]);
        logic signed [VALUE_W-1:0] v;
        t_result_beat              r;
        int                        pos;
        int                        k;
        v   = b.value;
        pos = 0;
        outq.delete();
        while (pos < held && shadow[pos] < v) pos++;
        r.element = v;
        r.last    = 1'b1;
        case (b.command)
            CMD_INSERT: begin
                if (pos < held && shadow[pos] == v) begin
                    r.status = ST_DUPLICATE;
                    dup_hits++;
                end else if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                    full_rejects++;
                end else begin
                    for (k = held; k > pos; k--) shadow[k] = shadow[k-1];
                    shadow[pos] = v;
                    held++;
                    r.status = ST_INSERTED;
                end
                r.count = 6'(held);
                outq.push_back(r);
            end
            CMD_REMOVE: begin
                if (pos < held && shadow[pos] == v) begin
                    for (k = pos; k + 1 < held; k++) shadow[k] = shadow[k+1];
                    held--;
                    r.status = ST_REMOVED;
                end else begin
                    r.status = ST_ABSENT;
                end
                r.count = 6'(held);
                outq.push_back(r);
            end
            CMD_DUMP: begin
                r.count = 6'(held);
                if (held == 0) begin
                    r.status = ST_EMPTY;
                    outq.push_back(r);
                end else begin
                    for (k = 0; k < held; k++) begin
                        r.status  = ST_LISTED;
                        r.element = shadow[k];
                        r.last    = (k == held - 1);
                        outq.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (held > peak_held) peak_held = held;
    endfunction

    always @(posedge i_clk) begin
        beat_taken = i_rst_n && i_start && !o_busy;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (results_due.size() == 0) begin
                $error("unexpected result beat: status %0d element %0d",
                       o_result.status, o_result.element);
                failures++;
            end else begin
                want = results_due.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    failures++;
                end
                if (o_result.element !== want.element) begin
                    $error("element: expected %0d, got %0d", want.element, o_result.element);
                    failures++;
                end
                if (o_result.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_result.count);
                    failures++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    failures++;
                end
            end
        end
        if (beat_taken) begin
            n_beats++;
            set_step(i_cmd, fresh);
            if (row_typed) begin
                results_due.push_back(row_want);
            end else begin
                foreach (fresh[j]) results_due.push_back(fresh[j]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            stall_run = 0;
        end else begin
            stall_run++;
            if (stall_run >= STALL_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic issue(input t_cmd_beat b, input logic typed, input t_result_beat w);
        while ($urandom_range(99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_cmd     = b;
        row_typed = typed;
        row_want  = w;
        i_start   = 1'b1;
        do @(negedge i_clk); while (!beat_taken);
    endtask

    // hold off until the set has answered everything, then let a silent
    // command finish its walk
    task automatic drain();
        i_start = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic t_cmd_beat random_beat(input int ins_w);
        t_cmd_beat b;
        int        r;
        int        s;
        r = $urandom_range(99);
        s = $urandom_range(9);
        if (r < 3)
            b.command = CMD_UNUSED;
        else if (r < 12)
            b.command = CMD_DUMP;
        else if (r < 12 + ins_w)
            b.command = CMD_INSERT;
        else
            b.command = CMD_REMOVE;
        if (s < 4 && held > 0)
            b.value = shadow[$urandom_range(held - 1)];
        else if (s < 8)
            b.value = 32'(int'($urandom_range(40)) - 20);
        else
            b.value = $urandom;
        return b;
    endfunction

    initial begin
        int        n;
        t_cmd_beat b;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cmd        = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        beat_taken   = 1'b0;
        held         = 0;
        failures     = 0;
        n_beats      = 0;
        n_results    = 0;
        peak_held    = 0;
        full_rejects = 0;
        dup_hits     = 0;
        stall_run    = 0;
        idle_pct     = 17;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NROWS; i++)
            issue(ROWS[i].beat, ROWS[i].typed, ROWS[i].want);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 17 : (ph == 1) ? 54 : 0;
            n = 0;
            if (ph == 0) begin
                while (held < CAPACITY) begin
                    b.command = CMD_INSERT;
                    b.value   = $urandom;
                    issue(b, 1'b0, '0);
                    n++;
                end
                b.command = CMD_INSERT;
                b.value   = $urandom;
                issue(b, 1'b0, '0);
                b.value = shadow[$urandom_range(CAPACITY - 1)];
                issue(b, 1'b0, '0);
                b.command = CMD_DUMP;
                issue(b, 1'b0, '0);
                n += 3;
            end
            while (n < PHASE_CMDS) begin
                issue(random_beat(((n / 20) % 2 == ph % 2) ? 70 : 25), 1'b0, '0);
                n++;
            end
            drain();
        end

        if (results_due.size() != 0) begin
            $error("%0d result beats never arrived", results_due.size());
            failures++;
        end
        $display("Ran %0d commands, checked %0d result beats.", n_beats, n_results);
        $display("Set peaked at %0d entries; %0d full rejects, %0d duplicates.",
                 peak_held, full_rejects, dup_hits);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/sus_pkg.sv
design/sus_ram.sv
design/sorted_unique_set_core.sv
tb/sv/tb_top.sv
